[rtl/core/wrm_pkg.sv]
// wrm_pkg: shared widths, register indexes and beat types of the window rms meter
// no dependencies; used by every file of the block but wrm_stream_if
package wrm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 64;
    localparam int PEAK_W     = 24;
    localparam int COUNT_W    = 16;
    localparam int SCALE_W    = 32;
    localparam int RMS_W      = 47;
    localparam int PEAK_NEG_W = 48;
    localparam int CREST_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 1'b1;

    localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RESET = 16'd1024;
    localparam logic [SCALE_W-1:0] SCALE_FACTOR_RESET  = 32'd65536;

    localparam logic [RMS_W-1:0] RMS_MAX = '1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } sample_t;

    typedef struct packed {
        logic [RMS_W-1:0]             rms_value;
        logic [RMS_W-1:0]             peak_positive;
        logic signed [PEAK_NEG_W-1:0] peak_negative;
        logic [CREST_W-1:0]           crest_factor;
    } result_t;

    // one closed window handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0]         sum;
        logic signed [PEAK_W-1:0] peak_max;
        logic signed [PEAK_W-1:0] peak_min;
        logic [COUNT_W-1:0]       count;
        logic [SCALE_W-1:0]       scale;
    } job_t;

endpackage

[rtl/core/wrm_stream_if.sv]
// wrm_stream_if: valid/ready stream channel carrying one payload beat
// payload type is a parameter; no other dependencies
interface wrm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/window_rms_peak_crest_meter_top.sv]
// window_rms_peak_crest_meter_top: samples enter one per cycle while the queue can take
// a closed window; the front closes a window after window_length beats, the back works
// on one window at a time (scale multiply, 128-step count division, 64-step root,
// 63-step crest division, skipped when the rms is zero); two windows may queue. reset
// clears accumulators, empties the queue and drops the result valid; it sets
// window_length=1024, scale=1.0
module window_rms_peak_crest_meter_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    wrm_stream_if.sink                     samples,
    wrm_stream_if.source                   results,
    input  logic                           cfg_we,
    input  logic [wrm_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [wrm_pkg::CFG_DATA_W-1:0] cfg_data
);
    logic [wrm_pkg::COUNT_W-1:0] wl_reg, wl_next;
    logic [wrm_pkg::SCALE_W-1:0] sf_reg, sf_next;

    wrm_stream_if #(.T(wrm_pkg::job_t)) front_jobs ();
    wrm_stream_if #(.T(wrm_pkg::job_t)) back_jobs ();

    always_comb
    begin
        wl_next = wl_reg;
        sf_next = sf_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                wrm_pkg::REG_WINDOW_LENGTH: wl_next = cfg_data[wrm_pkg::COUNT_W-1:0];
                wrm_pkg::REG_SCALE_FACTOR:  sf_next = cfg_data;
                default:                    wl_next = wl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= wrm_pkg::WINDOW_LENGTH_RESET;
            sf_reg <= wrm_pkg::SCALE_FACTOR_RESET;
        end
        else
        begin
            wl_reg <= wl_next;
            sf_reg <= sf_next;
        end
    end

    wrm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .jobs          (front_jobs),
        .window_length (wl_reg),
        .scale_factor  (sf_reg)
    );

    wrm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_jobs),
        .pop   (back_jobs)
    );

    wrm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .jobs    (back_jobs),
        .results (results)
    );

    // a closed window waiting on a full queue stays offered
    a_job_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (front_jobs.valid && !front_jobs.ready) |=> front_jobs.valid)
        else $error("closed window withdrawn while the queue was full");

    a_crest_zero_rms: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.data.rms_value != '0 || results.data.crest_factor == '0))
        else $error("crest factor nonzero with zero rms");

    a_neg_peak_sign: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.data.peak_negative[47] || results.data.peak_negative == '0))
        else $error("negative peak above zero");
endmodule

[rtl/core/wrm_front.sv]
// wrm_front: per-sample accumulation of square sum, peaks and window count
// depends on wrm_pkg and wrm_stream_if; emits one job beat per closed window
module wrm_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    wrm_stream_if.sink                   samples,
    wrm_stream_if.source                 jobs,
    input  logic [wrm_pkg::COUNT_W-1:0]  window_length,
    input  logic [wrm_pkg::SCALE_W-1:0]  scale_factor
);
    localparam int SW    = 2 * SAMPLE_BITS + 16;
    localparam int EXT_W = SAMPLE_BITS + wrm_pkg::SAMPLE_W;

    logic [SW-1:0]                   sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0]   max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0]   min_reg, min_next;
    logic [wrm_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;

    logic [EXT_W-1:0]                ext;
    logic [SAMPLE_BITS-1:0]          raw;
    logic signed [SAMPLE_BITS-1:0]   s;
    logic [SAMPLE_BITS-1:0]          mag;
    logic [2*SAMPLE_BITS-1:0]        mag_w;
    logic [2*SAMPLE_BITS-1:0]        sq;
    logic [SW-1:0]                   sum_add;
    logic signed [SAMPLE_BITS-1:0]   max_upd, min_upd;
    logic [wrm_pkg::COUNT_W:0]       cnt_inc;
    logic [wrm_pkg::COUNT_W-1:0]     limit;
    logic                            close;
    logic                            accept;

    assign ext     = {{SAMPLE_BITS{1'b0}}, samples.data.sample};
    assign raw     = ext[SAMPLE_BITS-1:0];
    assign s       = raw;
    assign mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign mag_w   = (2*SAMPLE_BITS)'(mag);
    assign sq      = mag_w * mag_w;
    assign sum_add = sum_reg + SW'(sq);
    assign max_upd = (s > max_reg) ? s : max_reg;
    assign min_upd = (s < min_reg) ? s : min_reg;
    assign cnt_inc = {1'b0, cnt_reg} + 17'd1;
    assign limit   = (window_length == '0) ? 16'd1 : window_length;
    // a shortened window closes on the next sample
    assign close   = cnt_inc >= {1'b0, limit};

    assign samples.ready = jobs.ready;
    assign accept        = samples.valid && samples.ready;

    assign jobs.valid         = samples.valid && close;
    assign jobs.data.sum      = wrm_pkg::SUM_W'(sum_add);
    assign jobs.data.peak_max = wrm_pkg::PEAK_W'(max_upd);
    assign jobs.data.peak_min = wrm_pkg::PEAK_W'(min_upd);
    assign jobs.data.count    = cnt_inc[wrm_pkg::COUNT_W-1:0];
    assign jobs.data.scale    = scale_factor;

    always_comb
    begin
        sum_next = sum_reg;
        max_next = max_reg;
        min_next = min_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (close)
            begin
                sum_next = '0;
                max_next = '0;
                min_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_add;
                max_next = max_upd;
                min_next = min_upd;
                cnt_next = cnt_inc[wrm_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            max_reg <= '0;
            min_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            max_reg <= max_next;
            min_reg <= min_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

[rtl/core/wrm_queue.sv]
// wrm_queue: two-entry job queue between the front and the back
// depends on wrm_pkg and wrm_stream_if
module wrm_queue (
    input  logic          clk,
    input  logic          rst_n,
    wrm_stream_if.sink    push,
    wrm_stream_if.source  pop
);
    wrm_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign push.ready = fill_reg != 2'd2;
    assign pop.valid  = fill_reg != 2'd0;
    assign pop.data   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push.ready;
    assign do_pop     = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end
endmodule

[rtl/core/wrm_back.sv]
// wrm_back: per-window math sequencer: scale, divide by count, square root, peaks,
// crest division unless rms is zero, result register; depends on wrm_pkg, wrm_stream_if
module wrm_back (
    input  logic          clk,
    input  logic          rst_n,
    wrm_stream_if.sink    jobs,
    wrm_stream_if.source  results
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_PEAK  = 3'd5;
    localparam logic [2:0] ST_CREST = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]              state_reg, state_next;
    wrm_pkg::job_t           job_reg, job_next;
    logic [63:0]             s2_reg, s2_next;
    logic [127:0]            x_reg, x_next;
    logic [65:0]             rem_reg, rem_next;
    logic [63:0]             root_reg, root_next;
    logic [6:0]              cnt_reg, cnt_next;
    logic [46:0]             rms_reg, rms_next;
    logic [46:0]             pos_reg, pos_next;
    logic signed [47:0]      neg_reg, neg_next;
    logic [62:0]             cd_reg, cd_next;
    wrm_pkg::result_t        out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [63:0]  s2_prod;
    logic [79:0]  part;
    logic [16:0]  div_t;
    logic         div_ge;
    logic [67:0]  sq_t;
    logic [67:0]  sq_trial;
    logic         sq_ge;
    logic [23:0]  maxu, minu;
    logic [55:0]  pos_prod, neg_prod;
    logic [47:0]  negmag;
    logic [47:0]  cr_t;
    logic         cr_ge;

    assign jobs.ready    = state_reg == ST_IDLE;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    assign s2_prod  = 64'(job_reg.scale) * 64'(job_reg.scale);
    assign part     = 80'(job_reg.sum) * 80'(s2_reg[63:48]);
    assign div_t    = {rem_reg[15:0], x_reg[127]};
    assign div_ge   = div_t >= {1'b0, job_reg.count};
    assign sq_t     = {rem_reg, x_reg[127:126]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign maxu     = job_reg.peak_max;
    assign minu     = ~job_reg.peak_min + 24'd1;
    assign pos_prod = 56'(maxu) * 56'(job_reg.scale);
    assign neg_prod = 56'(minu) * 56'(job_reg.scale);
    assign negmag   = (neg_prod > 56'h800000000000) ? 48'h800000000000 : neg_prod[47:0];
    assign cr_t     = {rem_reg[46:0], cd_reg[62]};
    assign cr_ge    = cr_t >= {1'b0, rms_reg};

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        s2_next        = s2_reg;
        x_next         = x_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        rms_next       = rms_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        cd_next        = cd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !results.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (jobs.valid)
                begin
                    job_next   = jobs.data;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                s2_next    = s2_prod;
                x_next     = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // sum times scale squared, one 16-bit digit per cycle from the top
                x_next   = (x_reg << 16) + 128'(part);
                s2_next  = s2_reg << 16;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd3)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division by the sample count, quotient shifts into x
                rem_next = 66'(div_ge ? div_t - {1'b0, job_reg.count} : div_t);
                x_next   = {x_reg[126:0], div_ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // one root bit per cycle, two radicand bits consumed
                rem_next  = 66'(sq_ge ? sq_t - sq_trial : sq_t);
                root_next = {root_reg[62:0], sq_ge};
                x_next    = x_reg << 2;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                rms_next = (root_reg > 64'(wrm_pkg::RMS_MAX)) ? wrm_pkg::RMS_MAX
                                                              : root_reg[46:0];
                pos_next = (pos_prod > 56'(wrm_pkg::RMS_MAX)) ? wrm_pkg::RMS_MAX
                                                              : pos_prod[46:0];
                neg_next = 48'd0 - negmag;
                cd_next  = {pos_next, 16'd0};
                rem_next = '0;
                cnt_next = '0;
                if (rms_next == '0)
                begin
                    cd_next    = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_CREST;
                end
            end
            ST_CREST:
            begin
                rem_next = 66'(cr_ge ? cr_t - {1'b0, rms_reg} : cr_t);
                cd_next  = {cd_reg[61:0], cr_ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd62)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_next.rms_value     = rms_reg;
                    out_next.peak_positive = pos_reg;
                    out_next.peak_negative = neg_reg;
                    out_next.crest_factor  = (cd_reg[62:32] != '0) ? '1 : cd_reg[31:0];
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        s2_reg   <= s2_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rms_reg  <= rms_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        cd_reg   <= cd_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
